// File: rtl/cls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg
// Types and constants shared by the link supervisor modules.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int NODE_W = 6;
    localparam int MS_W   = 32;
    localparam int PER_W  = 16;
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // register map, index = paddr / 4
    localparam logic [IDX_W-1:0] REG_LINK_ENABLED  = 3'd0;
    localparam logic [IDX_W-1:0] REG_OWN_NODE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_BCAST_NODE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CMD_TIMEOUT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RETRY_IVL     = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORMAL_PERIOD = 3'd5;
    localparam logic [IDX_W-1:0] REG_PROBE_PERIOD  = 3'd6;

    localparam logic [NODE_W-1:0] RST_OWN_NODE      = 6'd1;
    localparam logic [NODE_W-1:0] RST_BCAST_NODE    = 6'd63;
    localparam logic [PER_W-1:0]  RST_CMD_TIMEOUT   = 16'd100;
    localparam logic [PER_W-1:0]  RST_RETRY_IVL     = 16'd100;
    localparam logic [PER_W-1:0]  RST_NORMAL_PERIOD = 16'd20;
    localparam logic [PER_W-1:0]  RST_PROBE_PERIOD  = 16'd500;

    localparam logic [CNT_W-1:0] SUPPRESS_STEP = 32'd2;

    // frame, ignored, timeout, bus-off, recovery, suppressed
    localparam int NUM_CNT      = 6;
    localparam int C_FRAMES     = 0;
    localparam int C_IGNORED    = 1;
    localparam int C_TIMEOUT    = 2;
    localparam int C_BUSOFF     = 3;
    localparam int C_RECOVERY   = 4;
    localparam int C_SUPPRESSED = 5;

    typedef struct packed {
        logic              link_enabled;
        logic [NODE_W-1:0] own_node;
        logic [NODE_W-1:0] broadcast_node;
        logic [PER_W-1:0]  command_timeout_ms;
        logic [PER_W-1:0]  retry_interval_ms;
        logic [PER_W-1:0]  normal_period_ms;
        logic [PER_W-1:0]  probe_period_ms;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] frame_node;
        logic [MS_W-1:0]   now_ms;
        logic              warn_in;
        logic              passive_in;
        logic              busoff_in;
    } t_request;

    typedef struct packed {
        logic             stand_down;
        logic             recover_request;
        logic             publish;
        logic             timed_out;
        logic             busoff_sticky;
        logic [CNT_W-1:0] frames_count;
        logic [CNT_W-1:0] ignored_count;
        logic [CNT_W-1:0] timeout_count;
        logic [CNT_W-1:0] busoff_count;
        logic [CNT_W-1:0] recovery_count;
        logic [CNT_W-1:0] suppressed_count;
    } t_result;

endpackage

// File: rtl/cls_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_cfg
// APB register bank for the link supervisor settings.
// ----------------------------------------------------------------------------
module cls_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cls_pkg::ADDR_W-1:0]   paddr,
    input  logic [cls_pkg::DATA_W-1:0]   pwdata,
    output logic [cls_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output cls_pkg::t_cfg                o_cfg
);

    cls_pkg::t_cfg                r_cfg;
    logic [cls_pkg::IDX_W-1:0]    idx;
    logic                         wr_en;

    assign idx    = paddr[cls_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_enabled       <= 1'b0;
            r_cfg.own_node           <= cls_pkg::RST_OWN_NODE;
            r_cfg.broadcast_node     <= cls_pkg::RST_BCAST_NODE;
            r_cfg.command_timeout_ms <= cls_pkg::RST_CMD_TIMEOUT;
            r_cfg.retry_interval_ms  <= cls_pkg::RST_RETRY_IVL;
            r_cfg.normal_period_ms   <= cls_pkg::RST_NORMAL_PERIOD;
            r_cfg.probe_period_ms    <= cls_pkg::RST_PROBE_PERIOD;
        end else if (wr_en) begin
            case (idx)
                cls_pkg::REG_LINK_ENABLED:  r_cfg.link_enabled <= pwdata[0];
                cls_pkg::REG_OWN_NODE:
                    r_cfg.own_node <= pwdata[cls_pkg::NODE_W-1:0];
                cls_pkg::REG_BCAST_NODE:
                    r_cfg.broadcast_node <= pwdata[cls_pkg::NODE_W-1:0];
                cls_pkg::REG_CMD_TIMEOUT:
                    r_cfg.command_timeout_ms <= pwdata[cls_pkg::PER_W-1:0];
                cls_pkg::REG_RETRY_IVL:
                    r_cfg.retry_interval_ms <= pwdata[cls_pkg::PER_W-1:0];
                cls_pkg::REG_NORMAL_PERIOD:
                    r_cfg.normal_period_ms <= pwdata[cls_pkg::PER_W-1:0];
                cls_pkg::REG_PROBE_PERIOD:
                    r_cfg.probe_period_ms <= pwdata[cls_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cls_pkg::REG_LINK_ENABLED:  prdata = {31'd0, r_cfg.link_enabled};
            cls_pkg::REG_OWN_NODE:      prdata = {26'd0, r_cfg.own_node};
            cls_pkg::REG_BCAST_NODE:    prdata = {26'd0, r_cfg.broadcast_node};
            cls_pkg::REG_CMD_TIMEOUT:   prdata = {16'd0, r_cfg.command_timeout_ms};
            cls_pkg::REG_RETRY_IVL:     prdata = {16'd0, r_cfg.retry_interval_ms};
            cls_pkg::REG_NORMAL_PERIOD: prdata = {16'd0, r_cfg.normal_period_ms};
            cls_pkg::REG_PROBE_PERIOD:  prdata = {16'd0, r_cfg.probe_period_ms};
            default:                    prdata = '0;
        endcase
    end

endmodule

// File: rtl/cls_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_core
// Supervisor state and the single-pass update for one request: frame
// acceptance, command watchdog, bus-off tracking and telemetry scheduling.
// ----------------------------------------------------------------------------
module cls_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cls_pkg::t_cfg     i_cfg,
    input  cls_pkg::t_request i_req,
    output cls_pkg::t_result  o_result
);

    logic                        r_armed, n_armed;
    logic                        r_timeout, n_timeout;
    logic [cls_pkg::MS_W-1:0]    r_last_rx, n_last_rx;
    logic                        r_busoff, n_busoff;
    logic                        r_latched, n_latched;
    logic [cls_pkg::MS_W-1:0]    r_recover, n_recover;
    logic [cls_pkg::MS_W-1:0]    r_slot, n_slot;
    logic [cls_pkg::MS_W-1:0]    r_telem, n_telem;
    logic [cls_pkg::CNT_W-1:0]   r_cnt [cls_pkg::NUM_CNT];
    logic [cls_pkg::CNT_W-1:0]   n_cnt [cls_pkg::NUM_CNT];

    logic                        sd, rec, pub;
    logic                        node_hit, wd_fire, entry, tf1;
    logic                        withheld, slot_fire;
    logic [cls_pkg::MS_W-1:0]    now, period;
    logic [cls_pkg::MS_W-1:0]    normal32;

    assign now      = i_req.now_ms;
    assign normal32 = {16'd0, i_cfg.normal_period_ms};
    assign node_hit = (i_req.frame_node == i_cfg.own_node) ||
                      (i_req.frame_node == i_cfg.broadcast_node);
    assign wd_fire  = r_armed && !r_timeout &&
                      ((now - r_last_rx) >= {16'd0, i_cfg.command_timeout_ms});
    assign entry    = i_req.busoff_in && !r_busoff;
    assign tf1      = r_timeout || wd_fire;

    // warn/passive status is used only within the poll that reports it,
    // so the scheduler reads the poll values directly
    always_comb begin
        n_armed   = r_armed;
        n_timeout = r_timeout;
        n_last_rx = r_last_rx;
        n_busoff  = r_busoff;
        n_latched = r_latched;
        n_recover = r_recover;
        n_slot    = r_slot;
        n_telem   = r_telem;
        for (int i = 0; i < cls_pkg::NUM_CNT; i++) n_cnt[i] = r_cnt[i];
        sd       = 1'b0;
        rec      = 1'b0;
        pub      = 1'b0;
        period   = normal32;
        withheld = 1'b0;
        slot_fire = 1'b0;

        if (i_cfg.link_enabled) begin
            if (i_req.mode) begin
                if (node_hit) begin
                    n_cnt[cls_pkg::C_FRAMES] = r_cnt[cls_pkg::C_FRAMES] + 1'b1;
                    n_last_rx = now;
                    n_armed   = 1'b1;
                    n_timeout = 1'b0;
                end else begin
                    n_cnt[cls_pkg::C_IGNORED] = r_cnt[cls_pkg::C_IGNORED] + 1'b1;
                end
            end else begin
                // watchdog
                if (wd_fire) begin
                    n_cnt[cls_pkg::C_TIMEOUT] = r_cnt[cls_pkg::C_TIMEOUT] + 1'b1;
                    n_timeout = 1'b1;
                    sd        = 1'b1;
                end
                // bus-off; on entry the pacing check always passes
                n_busoff  = i_req.busoff_in;
                if (entry) begin
                    n_cnt[cls_pkg::C_BUSOFF] = r_cnt[cls_pkg::C_BUSOFF] + 1'b1;
                    n_latched = 1'b1;
                    if (r_armed && !tf1) begin
                        n_timeout = 1'b1;
                        sd        = 1'b1;
                    end
                end
                if (i_req.busoff_in && (entry ||
                    ((now - r_recover) >= {16'd0, i_cfg.retry_interval_ms}))) begin
                    n_recover = now;
                    rec       = 1'b1;
                    n_cnt[cls_pkg::C_RECOVERY] = r_cnt[cls_pkg::C_RECOVERY] + 1'b1;
                end
                // telemetry
                if (i_req.busoff_in) begin
                    withheld = 1'b1;
                end else if (i_req.warn_in || i_req.passive_in) begin
                    period   = {16'd0, i_cfg.probe_period_ms};
                    withheld = (i_cfg.probe_period_ms != i_cfg.normal_period_ms);
                end
                slot_fire = (now - r_slot) >= normal32;
                if (slot_fire) begin
                    n_slot = now;
                    if (withheld) begin
                        n_cnt[cls_pkg::C_SUPPRESSED] =
                            r_cnt[cls_pkg::C_SUPPRESSED] + cls_pkg::SUPPRESS_STEP;
                    end
                end
                if (!i_req.busoff_in && ((now - r_telem) >= period)) begin
                    n_telem = now;
                    pub     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_timeout <= 1'b0;
            r_last_rx <= '0;
            r_busoff  <= 1'b0;
            r_latched <= 1'b0;
            r_recover <= '0;
            r_slot    <= '0;
            r_telem   <= '0;
            for (int i = 0; i < cls_pkg::NUM_CNT; i++) r_cnt[i] <= '0;
        end else if (i_fire) begin
            r_armed   <= n_armed;
            r_timeout <= n_timeout;
            r_last_rx <= n_last_rx;
            r_busoff  <= n_busoff;
            r_latched <= n_latched;
            r_recover <= n_recover;
            r_slot    <= n_slot;
            r_telem   <= n_telem;
            for (int i = 0; i < cls_pkg::NUM_CNT; i++) r_cnt[i] <= n_cnt[i];
        end
    end

    assign o_result.stand_down       = sd;
    assign o_result.recover_request  = rec;
    assign o_result.publish          = pub;
    assign o_result.timed_out        = n_timeout;
    assign o_result.busoff_sticky    = n_latched;
    assign o_result.frames_count     = n_cnt[cls_pkg::C_FRAMES];
    assign o_result.ignored_count    = n_cnt[cls_pkg::C_IGNORED];
    assign o_result.timeout_count    = n_cnt[cls_pkg::C_TIMEOUT];
    assign o_result.busoff_count     = n_cnt[cls_pkg::C_BUSOFF];
    assign o_result.recovery_count   = n_cnt[cls_pkg::C_RECOVERY];
    assign o_result.suppressed_count = n_cnt[cls_pkg::C_SUPPRESSED];

endmodule

// File: rtl/can_link_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_link_supervisor
// Control link supervisor: frame filter, command watchdog, bus-off recovery
// pacing and telemetry scheduling, with an APB settings port.
// ----------------------------------------------------------------------------
// Each request (a received frame or a poll pass) gives exactly one result.
// A request is registered on acceptance, evaluated by the supervisor core
// and captured in the result register, which presents it on m_axis. The
// block takes one request per clock while m_axis is not stalled. While a
// result waits on m_axis_tready the input register still takes one more
// request; after that s_axis_tready drops. The user must write settings
// over APB only while no request is in flight; it is not enforced.
module can_link_supervisor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [5:0] frame_node, [37:6] now_ms, [38] warn_in, [39] passive_in,
    // [40] busoff_in, [47:41] zero
    input  logic [47:0]   s_axis_tdata,
    // [0] mode
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [0] stand_down, [1] recover_request, [2] publish, [3] timed_out,
    // [4] busoff_sticky, [36:5] frames_count, [68:37] ignored_count,
    // [100:69] timeout_count, [132:101] busoff_count,
    // [164:133] recovery_count, [196:165] suppressed_count, [199:197] zero
    output logic [199:0]  m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    cls_pkg::t_cfg      cfg;
    cls_pkg::t_request  r_req;
    cls_pkg::t_result   core_res;
    cls_pkg::t_result   r_res;
    logic               r_in_vld;
    logic               r_out_vld;
    logic               advance;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req.mode       <= s_axis_tuser[0];
            r_req.frame_node <= s_axis_tdata[5:0];
            r_req.now_ms     <= s_axis_tdata[37:6];
            r_req.warn_in    <= s_axis_tdata[38];
            r_req.passive_in <= s_axis_tdata[39];
            r_req.busoff_in  <= s_axis_tdata[40];
        end
    end

    cls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cls_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_cfg    (cfg),
        .i_req    (r_req),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'd0,
                            r_res.suppressed_count,
                            r_res.recovery_count,
                            r_res.busoff_count,
                            r_res.timeout_count,
                            r_res.ignored_count,
                            r_res.frames_count,
                            r_res.busoff_sticky,
                            r_res.timed_out,
                            r_res.publish,
                            r_res.recover_request,
                            r_res.stand_down};

endmodule
